// File: rtl/es2c_pkg.sv
// Shared types, constants and tables for the epoch seconds to calendar converter.
package es2c_pkg;

    localparam int UNIT_W = 32;

    localparam logic [UNIT_W-1:0] SECS_PER_DAY  = 32'd86400;
    localparam logic [UNIT_W-1:0] SECS_PER_HOUR = 32'd3600;
    localparam logic [UNIT_W-1:0] SECS_PER_MIN  = 32'd60;
    localparam logic [UNIT_W-1:0] DAYS_LEAP     = 32'd366;
    localparam logic [UNIT_W-1:0] DAYS_COMMON   = 32'd365;
    localparam logic [UNIT_W-1:0] DAYS_PER_WEEK = 32'd7;
    // first second after 2099-12-31 23:59:59
    localparam logic [UNIT_W-1:0] END_SECS      = 32'd4102444800;

    localparam logic [11:0] FIRST_YEAR   = 12'd1970;
    localparam logic [11:0] CENTURY_BASE = 12'd1900;
    localparam logic [3:0]  LAST_MONTH   = 4'd11;

    typedef struct packed {
        logic [2:0]  weekday;
        logic [5:0]  seconds;
        logic [5:0]  minutes;
        logic [4:0]  hours;
        logic [4:0]  cal_day;
        logic [3:0]  cal_month;
        logic [11:0] cal_year;
        logic        beyond_range;
    } cal_result_t;

    // month is zero based
    function automatic logic [8:0] month_len(input logic [3:0] month, input logic leap);
        logic [8:0] len;
        begin
            case (month)
                4'd1:                      len = leap ? 9'd29 : 9'd28;
                4'd3, 4'd5, 4'd8, 4'd10:   len = 9'd30;
                default:                   len = 9'd31;
            endcase
            return len;
        end
    endfunction

    function automatic logic [2:0] month_corr(input logic [3:0] month);
        logic [2:0] c;
        begin
            case (month)
                4'd0:    c = 3'd0;
                4'd1:    c = 3'd3;
                4'd2:    c = 3'd3;
                4'd3:    c = 3'd6;
                4'd4:    c = 3'd1;
                4'd5:    c = 3'd4;
                4'd6:    c = 3'd6;
                4'd7:    c = 3'd2;
                4'd8:    c = 3'd5;
                4'd9:    c = 3'd0;
                4'd10:   c = 3'd3;
                4'd11:   c = 3'd5;
                default: c = 3'd0;
            endcase
            return c;
        end
    endfunction

endpackage

// File: rtl/epoch_seconds_to_calendar.sv
// Top level: stream ports, output register and the conversion sequencer.
//
// Converts a 32-bit count of seconds since 1970-01-01 00:00:00 into the
// Gregorian date, time of day and weekday (0 is Sunday), valid for 1970..2099.
// Input word on s_axis_*, one result word on m_axis_* for every input word.
// A count after the end of 2099 returns m_axis_tuser = 1 with all tdata fields 0.
//
// The sequencer runs the range check, the divisions and the walks through
// one 32-bit compare/subtract unit, with a separate adder for the weekday sum:
// 16 steps for the day split, 5 for hours, 6 for minutes, one step per
// elapsed year and per elapsed month plus a closing step for each walk,
// 7 for the weekday, then the result passes into the output register; an
// out-of-range count skips straight to that hand-over. s_axis_tready is high
// only while the sequencer is idle, so the next word is not taken until the
// previous result has been handed to the output register.
//
// The finished word sits in an output register, so the sequencer accepts the
// next input while m_axis is stalled; it holds its result until that register
// frees. Reset empties the output register and returns the sequencer to idle.
module epoch_seconds_to_calendar (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] epoch_seconds
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [11:0] cal_year, [15:12] cal_month, [20:16] cal_day, [25:21] hours,
    // [31:26] minutes, [37:32] seconds, [40:38] weekday, [47:41] zero
    output logic [47:0] m_axis_tdata,
    output logic        m_axis_tuser    // [0] beyond_range
);
    import es2c_pkg::*;

    logic        idle;
    logic        res_valid;
    logic        res_take;
    cal_result_t res;

    logic        out_valid_reg;
    logic        out_valid_next;
    cal_result_t out_reg;

    es2c_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (s_axis_tvalid && idle),
        .secs_in   (s_axis_tdata),
        .idle      (idle),
        .res_valid (res_valid),
        .res_take  (res_take),
        .res       (res)
    );

    assign res_take = res_valid && (!out_valid_reg || m_axis_tready);

    always_comb
    begin
        if (res_take)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (res_take)
                out_reg <= res;
        end
    end

    assign s_axis_tready = idle;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.beyond_range;
    assign m_axis_tdata  = {7'b0, out_reg.weekday, out_reg.seconds, out_reg.minutes,
                            out_reg.hours, out_reg.cal_day, out_reg.cal_month,
                            out_reg.cal_year};

endmodule

// File: rtl/es2c_sub.sv
// Compare and subtract unit shared by the range check, division and walk steps of the sequencer.
module es2c_sub (
    input  logic [es2c_pkg::UNIT_W-1:0] a,
    input  logic [es2c_pkg::UNIT_W-1:0] b,
    output logic                        ge,
    output logic [es2c_pkg::UNIT_W-1:0] diff
);
    import es2c_pkg::*;

    logic [UNIT_W:0] wide_diff;

    assign wide_diff = {1'b0, a} - {1'b0, b};
    assign ge        = ~wide_diff[UNIT_W];
    assign diff      = wide_diff[UNIT_W-1:0];

endmodule

// File: rtl/es2c_ctrl.sv
// Sequencer that runs the conversion through the shared compare/subtract unit.
module es2c_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [es2c_pkg::UNIT_W-1:0] secs_in,
    output logic                        idle,
    output logic                        res_valid,
    input  logic                        res_take,
    output es2c_pkg::cal_result_t       res
);
    import es2c_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DAY,
        ST_HOUR,
        ST_MIN,
        ST_YEAR,
        ST_MONTH,
        ST_WSUM,
        ST_WMOD,
        ST_DONE
    } state_t;

    state_t             state_reg;
    logic [UNIT_W-1:0]  acc_reg;
    logic [15:0]        quot_reg;
    logic [15:0]        days_reg;
    logic [3:0]         cnt_reg;
    logic [11:0]        year_reg;
    logic [3:0]         month_reg;
    cal_result_t        res_reg;

    logic [UNIT_W-1:0]  unit_a;
    logic [UNIT_W-1:0]  unit_b;
    logic               unit_ge;
    logic [UNIT_W-1:0]  unit_diff;
    logic [UNIT_W-1:0]  rem_next;
    logic [15:0]        quot_next;
    logic               leap;
    logic [7:0]         yl;
    logic [5:0]         day_num;
    logic [8:0]         wsum;

    // 2000 is a leap year, 2100 is never reached
    assign leap = (year_reg[1:0] == 2'b00);

    always_comb
    begin
        unit_a = (state_reg == ST_IDLE) ? secs_in : acc_reg;
        case (state_reg)
            ST_IDLE:  unit_b = END_SECS;
            ST_DAY:   unit_b = SECS_PER_DAY << cnt_reg;
            ST_HOUR:  unit_b = SECS_PER_HOUR << cnt_reg;
            ST_MIN:   unit_b = SECS_PER_MIN << cnt_reg;
            ST_YEAR:  unit_b = leap ? DAYS_LEAP : DAYS_COMMON;
            ST_MONTH: unit_b = {{(UNIT_W-9){1'b0}}, month_len(month_reg, leap)};
            ST_WMOD:  unit_b = DAYS_PER_WEEK << cnt_reg;
            default:  unit_b = '0;
        endcase
    end

    es2c_sub u_sub (
        .a    (unit_a),
        .b    (unit_b),
        .ge   (unit_ge),
        .diff (unit_diff)
    );

    assign rem_next  = unit_ge ? unit_diff : acc_reg;
    assign quot_next = {quot_reg[14:0], unit_ge};

    // weekday sum: yl + yl/4 + day + correction, minus one for Jan/Feb of a leap year
    assign yl      = 8'(year_reg - CENTURY_BASE);
    assign day_num = {1'b0, acc_reg[4:0]} + 6'd1;
    assign wsum    = {1'b0, yl} + {3'b000, yl[7:2]} + {3'b000, day_num}
                   + {6'b0, month_corr(month_reg)}
                   - {8'b0, (yl[1:0] == 2'b00) && (month_reg < 4'd2)};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            acc_reg   <= '0;
            quot_reg  <= '0;
            days_reg  <= '0;
            cnt_reg   <= '0;
            year_reg  <= FIRST_YEAR;
            month_reg <= '0;
            res_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        if (unit_ge)
                        begin
                            res_reg   <= '{beyond_range: 1'b1, default: '0};
                            state_reg <= ST_DONE;
                        end
                        else
                        begin
                            acc_reg   <= secs_in;
                            quot_reg  <= '0;
                            cnt_reg   <= 4'd15;
                            state_reg <= ST_DAY;
                        end
                    end
                end
                ST_DAY:
                begin
                    acc_reg <= rem_next;
                    if (cnt_reg == 4'd0)
                    begin
                        days_reg  <= quot_next;
                        quot_reg  <= '0;
                        cnt_reg   <= 4'd4;
                        state_reg <= ST_HOUR;
                    end
                    else
                    begin
                        quot_reg <= quot_next;
                        cnt_reg  <= cnt_reg - 4'd1;
                    end
                end
                ST_HOUR:
                begin
                    acc_reg <= rem_next;
                    if (cnt_reg == 4'd0)
                    begin
                        res_reg.hours <= quot_next[4:0];
                        quot_reg      <= '0;
                        cnt_reg       <= 4'd5;
                        state_reg     <= ST_MIN;
                    end
                    else
                    begin
                        quot_reg <= quot_next;
                        cnt_reg  <= cnt_reg - 4'd1;
                    end
                end
                ST_MIN:
                begin
                    if (cnt_reg == 4'd0)
                    begin
                        res_reg.minutes <= quot_next[5:0];
                        res_reg.seconds <= rem_next[5:0];
                        acc_reg         <= {{(UNIT_W-16){1'b0}}, days_reg};
                        year_reg        <= FIRST_YEAR;
                        state_reg       <= ST_YEAR;
                    end
                    else
                    begin
                        acc_reg  <= rem_next;
                        quot_reg <= quot_next;
                        cnt_reg  <= cnt_reg - 4'd1;
                    end
                end
                ST_YEAR:
                begin
                    if (unit_ge)
                    begin
                        acc_reg  <= unit_diff;
                        year_reg <= year_reg + 12'd1;
                    end
                    else
                    begin
                        month_reg <= '0;
                        state_reg <= ST_MONTH;
                    end
                end
                ST_MONTH:
                begin
                    // December takes whatever is left
                    if (unit_ge && (month_reg != LAST_MONTH))
                    begin
                        acc_reg   <= unit_diff;
                        month_reg <= month_reg + 4'd1;
                    end
                    else
                    begin
                        state_reg <= ST_WSUM;
                    end
                end
                ST_WSUM:
                begin
                    res_reg.cal_year  <= year_reg;
                    res_reg.cal_month <= month_reg + 4'd1;
                    res_reg.cal_day   <= day_num[4:0];
                    acc_reg           <= {{(UNIT_W-9){1'b0}}, wsum};
                    cnt_reg           <= 4'd5;
                    state_reg         <= ST_WMOD;
                end
                ST_WMOD:
                begin
                    acc_reg <= rem_next;
                    if (cnt_reg == 4'd0)
                    begin
                        res_reg.weekday      <= rem_next[2:0];
                        res_reg.beyond_range <= 1'b0;
                        state_reg            <= ST_DONE;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - 4'd1;
                    end
                end
                ST_DONE:
                begin
                    if (res_take)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign idle      = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);
    assign res       = res_reg;

    a_year_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_YEAR |-> year_reg < 12'd2100)
        else $error("year walk ran past 2099");

    a_month_days: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_MONTH |-> acc_reg < DAYS_LEAP)
        else $error("day of year out of range in month walk");

    a_wsum_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_WMOD |-> acc_reg < 32'd286)
        else $error("weekday sum out of range");

    a_time_fields: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_reg.beyond_range |->
            res_reg.hours < 5'd24 && res_reg.minutes < 6'd60 && res_reg.seconds < 6'd60)
        else $error("time of day field out of range");

    a_take_done: assert property (@(posedge clk) disable iff (!rst_n)
        res_take |-> state_reg == ST_DONE)
        else $error("result taken while not done");

endmodule

// File: tb/epoch_seconds_to_calendar_tb.sv
// Testbench for epoch_seconds_to_calendar: corner and random words checked against a calendar predictor.
`timescale 1ns / 1ps

module epoch_seconds_to_calendar_tb;

    import es2c_pkg::*;

    // Holds the predicted calendar words in arrival order and checks each result word.
    class calendar_checker;
        cal_result_t pending_dates[$];
        int unsigned month_days[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
        int unsigned month_offset[12] = '{0, 3, 3, 6, 1, 4, 6, 2, 5, 0, 3, 5};
        int errors;
        int checked;
        int noted;
        int past_end;
        int first_year;
        int last_year;

        function new();
            errors = 0;
            checked = 0;
            noted = 0;
            past_end = 0;
            first_year = 9999;
            last_year = 0;
        endfunction

        function bit is_leap(int unsigned yr);
            return (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
        endfunction

        // day of week by month-offset table; good for 1970..2099 only
        function int unsigned day_of_week(int unsigned yr, int unsigned mon, int unsigned dd);
            int unsigned yl;
            int unsigned acc;
            yl = yr % 100;
            if (yr / 100 > 19)
                yl += 100;
            acc = (yl + yl / 4) % 7;
            acc = acc + dd + month_offset[mon - 1];
            if (yl % 4 == 0 && mon < 3)
                acc -= 1;
            return acc % 7;
        endfunction

        function cal_result_t to_calendar(logic [31:0] secs);
            cal_result_t r;
            int unsigned days;
            int unsigned rem;
            int unsigned yr;
            int unsigned mon;
            int unsigned len;
            r = '0;
            if (secs >= END_SECS)
            begin
                r.beyond_range = 1'b1;
                return r;
            end
            days = secs / SECS_PER_DAY;
            rem = secs % SECS_PER_DAY;
            yr = FIRST_YEAR;
            len = is_leap(yr) ? DAYS_LEAP : DAYS_COMMON;
            while (days >= len)
            begin
                days -= len;
                yr++;
                len = is_leap(yr) ? DAYS_LEAP : DAYS_COMMON;
            end
            mon = 0;
            while (mon < 11)
            begin
                len = month_days[mon];
                if (mon == 1 && is_leap(yr))
                    len = 29;
                if (days < len)
                    break;
                days -= len;
                mon++;
            end
            r.cal_year = yr[11:0];
            r.cal_month = 4'(mon + 1);
            r.cal_day = 5'(days + 1);
            r.hours = 5'(rem / SECS_PER_HOUR);
            r.minutes = 6'((rem % SECS_PER_HOUR) / SECS_PER_MIN);
            r.seconds = 6'(rem % SECS_PER_MIN);
            r.weekday = 3'(day_of_week(yr, mon + 1, days + 1));
            return r;
        endfunction

        function void note_input(logic [31:0] secs);
            cal_result_t r;
            r = to_calendar(secs);
            pending_dates.push_back(r);
            noted++;
            if (r.beyond_range)
                past_end++;
            else
            begin
                if (r.cal_year < first_year)
                    first_year = r.cal_year;
                if (r.cal_year > last_year)
                    last_year = r.cal_year;
            end
        endfunction

        function void compare(string name, int unsigned want, int unsigned got);
            if (want != got)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            end
        endfunction

        function void check_result(logic [47:0] data, logic flag);
            cal_result_t want;
            if (pending_dates.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result word, expected none, actual data=%h flag=%b",
                         $time, data, flag);
                return;
            end
            want = pending_dates.pop_front();
            compare("cal_year", want.cal_year, data[11:0]);
            compare("cal_month", want.cal_month, data[15:12]);
            compare("cal_day", want.cal_day, data[20:16]);
            compare("hours", want.hours, data[25:21]);
            compare("minutes", want.minutes, data[31:26]);
            compare("seconds", want.seconds, data[37:32]);
            compare("weekday", want.weekday, data[40:38]);
            compare("pad", 0, data[47:41]);
            compare("beyond_range", want.beyond_range, flag);
            checked++;
        endfunction

        function int pending_count();
            return pending_dates.size();
        endfunction
    endclass

    localparam int RANDOM_WORDS = 800;
    localparam int DAY_COUNT = 47482;   // days from 1970-01-01 to the end of 2099

    logic        clk;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic        m_tuser;

    calendar_checker dates;
    bit src_rush;
    bit sink_rush;

    logic [31:0] corner_secs[] = '{
        32'd0, 32'd1, 32'd59, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
        32'd31535999,               // 1970-12-31 23:59:59
        32'd68169600,               // 1972-02-29
        32'd94608000,               // 1972-12-31, leap year end
        32'd94694399,
        32'd951782400,              // 2000-02-29
        32'd978220800,              // 2000-12-31
        32'd2147483647, 32'd2147483648,
        32'h55555555, 32'hAAAAAAAA,
        32'd4007836799,             // 2096-12-31 23:59:59
        32'd4102358400,             // 2099-12-31 00:00:00
        32'd4102444799,             // last in-range second
        32'd4102444800,             // first out-of-range second
        32'hFFFFFFFF
    };

    epoch_seconds_to_calendar u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #8_000_000;
        $display("Verification failed");
        $finish;
    end

    // returns at the edge where the word was taken; tvalid stays high for a back-to-back word
    task automatic send_epoch(input logic [31:0] secs);
        int gap;
        if ($urandom_range(0, 19) == 0)
            src_rush = !src_rush;
        gap = src_rush ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= secs;
        do
            @(posedge clk);
        while (!s_tready);
        dates.note_input(secs);
    endtask

    function automatic logic [31:0] random_epoch();
        logic [31:0] v;
        int unsigned day;
        case ($urandom_range(0, 9))
            6: v = $urandom();
            7:
            begin
                day = $urandom_range(0, DAY_COUNT - 1);
                case ($urandom_range(0, 2))
                    0: v = day * SECS_PER_DAY;
                    1: v = day * SECS_PER_DAY + SECS_PER_DAY - 1;
                    default: v = day * SECS_PER_DAY + $urandom_range(0, 59);
                endcase
            end
            8: v = $urandom_range(END_SECS, 32'hFFFFFFFF);
            9: v = $urandom_range(0, 40 * SECS_PER_DAY);
            default: v = $urandom_range(0, END_SECS - 1);
        endcase
        return v;
    endfunction

    // result side: random stalls, check every word taken
    initial
    begin
        int stall;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 19) == 0)
                sink_rush = !sink_rush;
            stall = sink_rush ? 0 : $urandom_range(0, 13);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            dates.check_result(m_tdata, m_tuser);
        end
    end

    initial
    begin
        dates = new();
        src_rush = 1'b0;
        sink_rush = 1'b0;
        rst_n <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (corner_secs[i])
            send_epoch(corner_secs[i]);
        for (int i = 0; i < RANDOM_WORDS; i++)
            send_epoch(random_epoch());
        s_tvalid <= 1'b0;

        while (dates.pending_count() > 0)
            @(posedge clk);
        repeat (200) @(posedge clk);

        $display("Converted %0d counts, %0d results checked, %0d past the end of 2099.",
                 dates.noted, dates.checked, dates.past_end);
        $display("In-range dates spanned years %0d to %0d.", dates.first_year, dates.last_year);
        if (dates.errors == 0 && dates.pending_count() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
